>>> src/shmp_pkg.sv
package shmp_pkg;

	localparam int STORE_DEPTH = 24;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	localparam logic [7:0] TYPE_MASTERING = 8'd137;
	localparam logic [7:0] TYPE_LIGHT = 8'd144;
	localparam logic [7:0] TYPE_TRANSFER = 8'd147;

	localparam logic [15:0] CHROMA_LIMIT = 16'd50000;
	localparam logic [CNT_W-1:0] MAST_BYTES = CNT_W'(STORE_DEPTH);
	localparam logic [CNT_W-1:0] CLL_BYTES = CNT_W'(4);

	localparam logic [3:0] MAST_WIDE_IDX = 4'd8;
	localparam logic [3:0] MAST_LAST_IDX = 4'd9;
	localparam logic [3:0] LIGHT_LAST_IDX = 4'd1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SHORT = 2'd1,
		ST_INVALID = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_MAST = 2'd0,
		KIND_LIGHT = 2'd1,
		KIND_XFER = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef logic [STORE_DEPTH-1:0][7:0] bytes_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] data_byte;
		logic last_byte;
	} in_t;

	typedef struct packed {
		status_t status;
		logic [3:0] value_index;
		logic [31:0] value;
		logic last_result;
	} out_t;

	typedef struct packed {
		status_t status;
		kind_t kind;
		bytes_t bytes;
	} job_t;

endpackage

>>> src/sei_hdr_metadata_parser.sv
// channel  | handshake          | payload             | beat
// ---------+--------------------+---------------------+-------------------------------
// input    | push / full        | item   (in_t)       | one SEI payload byte + type
// result   | empty / pop        | result (out_t)      | one decoded value or error
//
// Cycles: one byte beat per cycle; a payload, even of one byte, may end every cycle.
// Rate: a run of 1, 2 or 10 result beats leaves the back sequencer one per cycle.
// Path: final byte -> job queue -> back run registers -> result queue -> ports.
// Stalls: full rises when the job queue holds JOB_DEPTH payloads; pop held low fills the
//   result queue, then halts the sequencer and the job queue behind it.
// Reset: arst_n clears the byte count, queues and sequencer; stored bytes keep garbage.
module sei_hdr_metadata_parser #(
	parameter int JOB_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input shmp_pkg::in_t item,
	output logic empty,
	input logic pop,
	output shmp_pkg::out_t result
);

	localparam int JOB_W = $bits(shmp_pkg::job_t);
	localparam int OUT_W = $bits(shmp_pkg::out_t);

	logic in_accept;
	logic jq_push;
	logic jq_full;
	logic jq_empty;
	logic jq_pop;
	shmp_pkg::job_t front_job;
	logic [JOB_W-1:0] jq_rd;
	logic res_push;
	logic res_full;
	shmp_pkg::out_t res;
	logic [OUT_W-1:0] oq_rd;

	// accept a byte whenever the job queue can take a finished payload
	assign full = jq_full;
	assign in_accept = push && !full;
	assign jq_push = in_accept && item.last_byte;

	// front: count, hold the first bytes, classify on the final byte
	shmp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_accept),
		.item(item),
		.job(front_job)
	);

	// decoupling queue of classified payloads
	shmp_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(jq_push),
		.wr_data(front_job),
		.rd_en(jq_pop),
		.rd_data(jq_rd),
		.full(jq_full),
		.empty(jq_empty)
	);

	// back: walk each payload's run of values
	shmp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(!jq_empty),
		.job(shmp_pkg::job_t'(jq_rd)),
		.job_pop(jq_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res)
	);

	// result queue: hold beats while the consumer stalls
	shmp_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_push),
		.wr_data(res),
		.rd_en(pop),
		.rd_data(oq_rd),
		.full(res_full),
		.empty(empty)
	);

	assign result = shmp_pkg::out_t'(oq_rd);

	// an error run is a single zero-valued beat
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != shmp_pkg::ST_OK) |->
		(result.last_result && result.value == '0 && result.value_index == '0))
		else $error("error result not a single zero beat");

	// the final mastering value closes its run
	a_mast_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == shmp_pkg::ST_OK &&
		result.value_index == shmp_pkg::MAST_LAST_IDX) |-> result.last_result)
		else $error("last mastering value without end mark");

	// back-to-back beats within a run step the index by one
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		($past(res_push && !res.last_result) && res_push) |->
		(res.value_index == 4'($past(res.value_index) + 4'd1)))
		else $error("result index skipped inside a run");

endmodule

>>> src/shmp_fifo.sv
module shmp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic full,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/shmp_front.sv
module shmp_front (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input shmp_pkg::in_t item,
	output shmp_pkg::job_t job
);

	logic [7:0] store_q [shmp_pkg::STORE_DEPTH];
	logic [shmp_pkg::CNT_W-1:0] count_q;
	logic [shmp_pkg::CNT_W-1:0] cnt_new;
	logic room;
	shmp_pkg::bytes_t merged;
	logic chroma_bad;
	logic [31:0] lum_max;
	logic [31:0] lum_min;
	logic [15:0] cll;
	logic [15:0] fall;

	assign room = (count_q < shmp_pkg::MAST_BYTES);
	assign cnt_new = room ? count_q + 1'b1 : count_q;

	// current byte folded in so the final byte is part of the decode
	always_comb begin
		for (int i = 0; i < shmp_pkg::STORE_DEPTH; i++) begin
			merged[i] = (room && count_q == shmp_pkg::CNT_W'(i)) ? item.data_byte : store_q[i];
		end
	end

	always_comb begin
		chroma_bad = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if ({merged[2*i], merged[2*i+1]} > shmp_pkg::CHROMA_LIMIT) begin
				chroma_bad = 1'b1;
			end
		end
	end

	assign lum_max = {merged[16], merged[17], merged[18], merged[19]};
	assign lum_min = {merged[20], merged[21], merged[22], merged[23]};
	assign cll = {merged[0], merged[1]};
	assign fall = {merged[2], merged[3]};

	always_comb begin
		job.bytes = merged;
		job.kind = shmp_pkg::KIND_NONE;
		job.status = shmp_pkg::ST_UNKNOWN;
		case (item.opcode)
			shmp_pkg::TYPE_MASTERING: begin
				job.kind = shmp_pkg::KIND_MAST;
				if (cnt_new < shmp_pkg::MAST_BYTES) begin
					job.status = shmp_pkg::ST_SHORT;
				end else if (chroma_bad || lum_max == '0 || lum_min >= lum_max) begin
					job.status = shmp_pkg::ST_INVALID;
				end else begin
					job.status = shmp_pkg::ST_OK;
				end
			end
			shmp_pkg::TYPE_LIGHT: begin
				job.kind = shmp_pkg::KIND_LIGHT;
				if (cnt_new < shmp_pkg::CLL_BYTES) begin
					job.status = shmp_pkg::ST_SHORT;
				end else if (cll == '0 || fall > cll) begin
					job.status = shmp_pkg::ST_INVALID;
				end else begin
					job.status = shmp_pkg::ST_OK;
				end
			end
			shmp_pkg::TYPE_TRANSFER: begin
				job.kind = shmp_pkg::KIND_XFER;
				job.status = shmp_pkg::ST_OK;
			end
			default: begin
				job.kind = shmp_pkg::KIND_NONE;
				job.status = shmp_pkg::ST_UNKNOWN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && room) begin
			store_q[count_q[shmp_pkg::CNT_W-1:0]] <= item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= item.last_byte ? '0 : cnt_new;
		end
	end

endmodule

>>> src/shmp_back.sv
module shmp_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input shmp_pkg::job_t job,
	output logic job_pop,
	input logic res_full,
	output logic res_push,
	output shmp_pkg::out_t res
);

	logic run_valid_q;
	shmp_pkg::status_t run_status_q;
	shmp_pkg::kind_t run_kind_q;
	shmp_pkg::bytes_t run_b_q;
	logic [3:0] run_idx_q;
	logic wide;
	logic res_last;
	shmp_pkg::bytes_t sh_next;

	assign wide = (run_kind_q == shmp_pkg::KIND_MAST) && (run_idx_q >= shmp_pkg::MAST_WIDE_IDX);

	always_comb begin
		res_last = 1'b1;
		res.value = '0;
		if (run_status_q == shmp_pkg::ST_OK) begin
			case (run_kind_q)
				shmp_pkg::KIND_MAST: begin
					res_last = (run_idx_q == shmp_pkg::MAST_LAST_IDX);
					res.value = wide ? {run_b_q[0], run_b_q[1], run_b_q[2], run_b_q[3]}
						: {16'd0, run_b_q[0], run_b_q[1]};
				end
				shmp_pkg::KIND_LIGHT: begin
					res_last = (run_idx_q == shmp_pkg::LIGHT_LAST_IDX);
					res.value = {16'd0, run_b_q[0], run_b_q[1]};
				end
				shmp_pkg::KIND_XFER: begin
					res.value = {24'd0, run_b_q[0]};
				end
				default: begin
					res.value = '0;
				end
			endcase
		end
		res.status = run_status_q;
		res.value_index = (run_status_q == shmp_pkg::ST_OK) ? run_idx_q : 4'd0;
		res.last_result = res_last;
	end

	// advance the byte window by the width of the value just sent
	always_comb begin
		sh_next = '0;
		if (wide) begin
			for (int i = 0; i < shmp_pkg::STORE_DEPTH - 4; i++) begin
				sh_next[i] = run_b_q[i+4];
			end
		end else begin
			for (int i = 0; i < shmp_pkg::STORE_DEPTH - 2; i++) begin
				sh_next[i] = run_b_q[i+2];
			end
		end
	end

	assign res_push = run_valid_q && !res_full;
	assign job_pop = job_valid && (!run_valid_q || (res_push && res_last));

	always_ff @(posedge clk) begin
		if (job_pop) begin
			run_status_q <= job.status;
			run_kind_q <= job.kind;
			run_b_q <= job.bytes;
		end else if (res_push) begin
			run_b_q <= sh_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_idx_q <= '0;
		end else if (job_pop) begin
			run_valid_q <= 1'b1;
			run_idx_q <= '0;
		end else if (res_push) begin
			run_valid_q <= !res_last;
			run_idx_q <= run_idx_q + 1'b1;
		end
	end

endmodule

>>> bench/sei_result_checker.sv
`timescale 1ns / 1ps

// Watch both channels, decode each finished payload into its run of result
// beats and compare every popped beat against the oldest one still owed.
module sei_result_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input shmp_pkg::in_t item,
	input logic empty,
	input logic pop,
	input shmp_pkg::out_t result,
	output int fail_count,
	output int values_owed
);

	logic [shmp_pkg::CNT_W-1:0] byte_cnt;
	logic [7:0] kept [shmp_pkg::STORE_DEPTH];
	shmp_pkg::out_t owed_q [$];
	shmp_pkg::out_t want;

	initial begin
		fail_count = 0;
		values_owed = 0;
		byte_cnt = '0;
	end

	function automatic logic [15:0] be16(input int pos);
		return {kept[pos], kept[pos + 1]};
	endfunction

	function automatic logic [31:0] be32(input int pos);
		return {be16(pos), be16(pos + 2)};
	endfunction

	function automatic void queue_value(input shmp_pkg::status_t st, input logic [3:0] idx,
			input logic [31:0] v, input logic lst);
		shmp_pkg::out_t r;
		r.status = st;
		r.value_index = idx;
		r.value = v;
		r.last_result = lst;
		owed_q = {owed_q, r};
	endfunction

	function automatic void queue_error(input shmp_pkg::status_t st);
		queue_value(st, 4'd0, 32'd0, 1'b1);
	endfunction

	// Store the byte, and on the end mark decode the kept bytes.
	function automatic void absorb_byte(input shmp_pkg::in_t b);
		logic [31:0] vals [10];
		logic bad;
		logic [15:0] cll;
		logic [15:0] fall;
		int i;
		if (byte_cnt < shmp_pkg::STORE_DEPTH) begin
			kept[byte_cnt] = b.data_byte;
			byte_cnt = byte_cnt + 1'b1;
		end
		if (!b.last_byte)
			return;
		case (b.opcode)
			shmp_pkg::TYPE_MASTERING: begin
				if (byte_cnt < shmp_pkg::MAST_BYTES) begin
					queue_error(shmp_pkg::ST_SHORT);
				end else begin
					bad = 1'b0;
					for (i = 0; i < 8; i++) begin
						vals[i] = {16'd0, be16(2 * i)};
						if (vals[i] > {16'd0, shmp_pkg::CHROMA_LIMIT})
							bad = 1'b1;
					end
					vals[8] = be32(16);
					vals[9] = be32(20);
					if (vals[8] == 32'd0 || vals[9] >= vals[8])
						bad = 1'b1;
					if (bad)
						queue_error(shmp_pkg::ST_INVALID);
					else
						for (i = 0; i < 10; i++)
							queue_value(shmp_pkg::ST_OK, 4'(i), vals[i], i == 9);
				end
			end
			shmp_pkg::TYPE_LIGHT: begin
				if (byte_cnt < shmp_pkg::CLL_BYTES) begin
					queue_error(shmp_pkg::ST_SHORT);
				end else begin
					cll = be16(0);
					fall = be16(2);
					if (cll == 16'd0 || fall > cll) begin
						queue_error(shmp_pkg::ST_INVALID);
					end else begin
						queue_value(shmp_pkg::ST_OK, 4'd0, {16'd0, cll}, 1'b0);
						queue_value(shmp_pkg::ST_OK, shmp_pkg::LIGHT_LAST_IDX,
							{16'd0, fall}, 1'b1);
					end
				end
			end
			shmp_pkg::TYPE_TRANSFER:
				queue_value(shmp_pkg::ST_OK, 4'd0, {24'd0, kept[0]}, 1'b1);
			default: queue_error(shmp_pkg::ST_UNKNOWN);
		endcase
		byte_cnt = '0;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("mismatch %s: got %0h, want %0h at %0t", field, got, exp_val, $time);
		fail_count++;
	endtask

	// Compare before absorbing so a beat popped in the same cycle as a final byte
	// never matches the run that byte starts.
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_cnt = '0;
			owed_q.delete();
		end else begin
			if (pop && !empty) begin
				if (owed_q.size() == 0) begin
					report_mismatch("unexpected beat", result.value, 32'd0);
				end else begin
					want = owed_q.pop_front();
					if (result.status !== want.status)
						report_mismatch("status", 32'(result.status), 32'(want.status));
					if (result.value_index !== want.value_index)
						report_mismatch("value_index", 32'(result.value_index),
							32'(want.value_index));
					if (result.value !== want.value)
						report_mismatch("value", result.value, want.value);
					if (result.last_result !== want.last_result)
						report_mismatch("last_result", 32'(result.last_result),
							32'(want.last_result));
				end
			end
			if (push && !full)
				absorb_byte(item);
		end
		values_owed = owed_q.size();
	end

endmodule

>>> bench/tb_sei_hdr_metadata_parser.sv
`timescale 1ns / 1ps

module tb_sei_hdr_metadata_parser;

	localparam int IDLE_LIMIT = 2000;
	localparam int DIRECTED_BEATS = 25;
	localparam int RANDOM_BEATS = 440;
	localparam int PAY_MAX = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	shmp_pkg::in_t item = '0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	shmp_pkg::out_t result;

	int fail_count;
	int values_owed;

	// Payload bytes of the frame being built, in stream order.
	logic [7:0] pay [PAY_MAX];
	int burst_left = 0;
	int beats_sent = 0;
	int idle_cycles = 0;
	int pop_run = 0;
	int pop_mode = 0;

	sei_hdr_metadata_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	sei_result_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.fail_count(fail_count),
		.values_owed(values_owed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// Receiver: runs of steady pop, runs of stall and runs of coin-flip pop, so
	// back-pressure lands on every phase of a result run.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop_run == 0) begin
				pop_mode = $urandom_range(0, 7);
				pop_run = $urandom_range(1, 24);
			end
			pop_run--;
			case (pop_mode)
				0, 1, 2, 3: pop <= 1'b1;
				4, 5: pop <= 1'b0;
				default: pop <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Watchdog: end the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic void put16(input int pos, input logic [15:0] v);
		pay[pos] = v[15:8];
		pay[pos + 1] = v[7:0];
	endfunction

	function automatic void put32(input int pos, input logic [31:0] v);
		put16(pos, v[31:16]);
		put16(pos + 2, v[15:0]);
	endfunction

	// Fill the frame with noise so every bit of the data byte toggles.
	function automatic void scramble_pay();
		int i;
		for (i = 0; i < PAY_MAX; i++)
			pay[i] = 8'($urandom);
	endfunction

	// Build a mastering display body; when broken, violate at least one range rule.
	function automatic void load_mastering(input bit valid);
		logic [31:0] mx;
		logic [31:0] mn;
		int i;
		for (i = 0; i < 8; i++)
			case ($urandom_range(0, 7))
				0: put16(2 * i, 16'd0);
				1: put16(2 * i, shmp_pkg::CHROMA_LIMIT);
				default: put16(2 * i, 16'($urandom_range(0, 50000)));
			endcase
		case ($urandom_range(0, 5))
			0: mx = 32'd1;
			1: mx = 32'hFFFF_FFFF;
			default: begin
				mx = $urandom;
				if (mx == 32'd0)
					mx = 32'd1;
			end
		endcase
		case ($urandom_range(0, 3))
			0: mn = 32'd0;
			1: mn = mx - 1;
			default: mn = $urandom % mx;
		endcase
		if (!valid)
			case ($urandom_range(0, 3))
				0: put16(2 * $urandom_range(0, 7), 16'($urandom_range(50001, 65535)));
				1: mx = 32'd0;
				2: mn = mx;
				default: begin
					if (mx == 32'hFFFF_FFFF)
						mn = mx;
					else
						mn = mx + 1 + ($urandom % (32'hFFFF_FFFF - mx));
				end
			endcase
		put32(16, mx);
		put32(20, mn);
	endfunction

	// Build a light level body: maxCLL then maxFALL.
	function automatic void load_light(input bit valid);
		logic [15:0] cll;
		logic [15:0] fall;
		if (valid) begin
			cll = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
			fall = ($urandom_range(0, 3) == 0) ? cll : 16'($urandom_range(0, cll));
		end else if ($urandom_range(0, 1) == 0) begin
			cll = 16'd0;
			fall = 16'($urandom);
		end else begin
			cll = 16'($urandom_range(0, 65534));
			fall = 16'($urandom_range(cll + 1, 65535));
		end
		put16(0, cll);
		put16(2, fall);
	endfunction

	// Push one payload of len beats. The type rides on the final beat; with
	// mixed set, earlier beats carry random types the block must disregard.
	task automatic send_payload(input logic [7:0] ptype, input int len, input bit mixed);
		shmp_pkg::in_t b;
		int gap;
		int k;
		for (k = 0; k < len; k++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			b.opcode = (k == len - 1 || !mixed) ? ptype : 8'($urandom);
			b.data_byte = pay[k];
			b.last_byte = (k == len - 1);
			push <= 1'b1;
			item <= b;
			// Hold the beat until full is low at an edge.
			do @(posedge clk); while (full);
			burst_left--;
			beats_sent++;
		end
	endtask

	// Drop push and hold off until every owed result beat has been popped.
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		wait (values_owed == 0);
		burst_left = 0;
	endtask

	initial begin
		logic [7:0] ptype;
		int len;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-byte transfer payloads at both byte extremes.
		scramble_pay();
		pay[0] = 8'h00;
		send_payload(shmp_pkg::TYPE_TRANSFER, 1, 1'b0);
		pay[0] = 8'hFF;
		send_payload(shmp_pkg::TYPE_TRANSFER, 1, 1'b0);
		// Unknown types, the HDR10+ type among them.
		send_payload(8'd4, 1, 1'b0);
		send_payload(8'd0, 1, 1'b0);
		send_payload(8'd255, 1, 1'b0);
		// Light level: maxFALL equal to a full-scale maxCLL, then the smallest
		// legal pair, a short body, a zero maxCLL and maxFALL above maxCLL.
		put16(0, 16'hFFFF);
		put16(2, 16'hFFFF);
		send_payload(shmp_pkg::TYPE_LIGHT, 4, 1'b0);
		put16(0, 16'd1);
		put16(2, 16'd0);
		send_payload(shmp_pkg::TYPE_LIGHT, 4, 1'b1);
		send_payload(shmp_pkg::TYPE_LIGHT, 3, 1'b0);
		put16(0, 16'd0);
		send_payload(shmp_pkg::TYPE_LIGHT, 4, 1'b0);
		put16(0, 16'd5);
		put16(2, 16'd6);
		send_payload(shmp_pkg::TYPE_LIGHT, 4, 1'b1);
		// Mastering display cut to a single byte.
		send_payload(shmp_pkg::TYPE_MASTERING, 1, 1'b0);
		drain_results();

		// Random: mostly well-formed frames with random content, plus broken,
		// short, over-long and pure-noise ones.
		while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
			scramble_pay();
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				load_mastering(1'b1);
				ptype = shmp_pkg::TYPE_MASTERING;
				len = ($urandom_range(0, 2) == 0) ? $urandom_range(25, PAY_MAX)
					: shmp_pkg::STORE_DEPTH;
			end else if (pick < 42) begin
				load_mastering(1'b0);
				ptype = shmp_pkg::TYPE_MASTERING;
				len = $urandom_range(shmp_pkg::STORE_DEPTH, PAY_MAX);
			end else if (pick < 46) begin
				ptype = shmp_pkg::TYPE_MASTERING;
				len = $urandom_range(1, shmp_pkg::STORE_DEPTH - 1);
			end else if (pick < 61) begin
				load_light(1'b1);
				ptype = shmp_pkg::TYPE_LIGHT;
				len = ($urandom_range(0, 1) == 0) ? 4 : $urandom_range(5, PAY_MAX);
			end else if (pick < 69) begin
				load_light(1'b0);
				ptype = shmp_pkg::TYPE_LIGHT;
				len = $urandom_range(4, 8);
			end else if (pick < 73) begin
				ptype = shmp_pkg::TYPE_LIGHT;
				len = $urandom_range(1, 3);
			end else if (pick < 83) begin
				ptype = shmp_pkg::TYPE_TRANSFER;
				len = $urandom_range(1, PAY_MAX);
			end else if (pick < 93) begin
				case ($urandom_range(0, 3))
					0: ptype = 8'd4;
					1: ptype = 8'd0;
					2: ptype = 8'hFF;
					default: ptype = 8'($urandom);
				endcase
				if (ptype == shmp_pkg::TYPE_MASTERING || ptype == shmp_pkg::TYPE_LIGHT ||
						ptype == shmp_pkg::TYPE_TRANSFER)
					ptype = 8'd4;
				len = $urandom_range(1, PAY_MAX);
			end else begin
				ptype = 8'($urandom);
				len = $urandom_range(1, PAY_MAX);
			end
			send_payload(ptype, len, $urandom_range(0, 9) < 3);
			if ($urandom_range(0, 14) == 0)
				drain_results();
		end

		// Wind down: let the last runs drain and give stray beats time to show.
		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
src/shmp_pkg.sv
src/shmp_fifo.sv
src/shmp_front.sv
src/shmp_back.sv
src/sei_hdr_metadata_parser.sv
bench/sei_result_checker.sv
bench/tb_sei_hdr_metadata_parser.sv
